// ----- hdl/cfsg_pkg.sv -----
// ---------------------------------------------------------------------------
// cfsg_pkg
// Shared constants and types for the cube face sky gradient texel unit.
// ---------------------------------------------------------------------------
package cfsg_pkg;

    localparam int MAX_FACE_SIZE = 1024;
    localparam int FSZ_W         = 11;
    localparam int COL_W         = 24;
    localparam int IDX_W         = 2;

    // pipeline geometry
    localparam int NDIV  = 33;               // quotient bits of V^2*2^32/D
    localparam int NSQ   = 17;               // root bits of each square root
    localparam int NLINE = 3 + NDIV + 2 * NSQ;

    localparam logic [FSZ_W-1:0] FSZ_RESET = FSZ_W'(256);
    localparam logic [FSZ_W-1:0] FSZ_MAX   = FSZ_W'(MAX_FACE_SIZE);

    typedef enum logic [IDX_W-1:0] {
        REG_FACE_SIZE     = 2'd0,
        REG_TOP_COLOR     = 2'd1,
        REG_HORIZON_COLOR = 2'd2,
        REG_BOTTOM_COLOR  = 2'd3
    } t_reg_idx;

    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;

    // one stage of the digit-by-digit square root
    typedef struct packed {
        logic [33:0] rad;   // radicand bits still to consume, top pair first
        logic [19:0] rem;
        logic [16:0] root;
    } t_sq;

endpackage

// ----- hdl/cube_face_sky_gradient_texel_unit.sv -----
// ---------------------------------------------------------------------------
// cube_face_sky_gradient_texel_unit
// Procedural sky colour for one cube-map texel, one texel per clock while the output is not stalled.
// ---------------------------------------------------------------------------
// A user's view: give one texel (face, row, column) per beat on the slave
// stream and get its RGB colour back on the master stream, in order. The unit
// accepts a beat every clock unless the master side stalls. Three front stages
// feed the 33-step restoring divider, two 17-step square-root pipelines and
// the colour mix/output register. A master stall freezes the whole pipeline
// (tready follows it), nothing is lost or repeated. Registers are written
// through the plain write port; the user must write them only while the
// pipeline is empty (not enforced by the block). face_size above 1024 is
// saturated, indexes are 0 face_size, 1 top, 2 horizon, 3 bottom colour.
// ---------------------------------------------------------------------------
module cube_face_sky_gradient_texel_unit
    import cfsg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [COL_W-1:0]   i_cfg_wdata,
    // slave stream
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [23:0]        i_s_tdata,   // face[2:0], texel_row[12:3], texel_col[22:13]
    // master stream
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [23:0]        o_m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    // ---- configuration registers ----
    logic [FSZ_W-1:0] r_fsz;
    logic [COL_W-1:0] r_top, r_hor, r_bot;
    logic [FSZ_W-1:0] n_fsz;

    assign n_fsz = (i_cfg_wdata[FSZ_W-1:0] > FSZ_MAX) ? FSZ_MAX : i_cfg_wdata[FSZ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsz <= FSZ_RESET;
            r_top <= '0;
            r_hor <= '0;
            r_bot <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FACE_SIZE:     r_fsz <= n_fsz;
                REG_TOP_COLOR:     r_top <= i_cfg_wdata;
                REG_HORIZON_COLOR: r_hor <= i_cfg_wdata;
                REG_BOTTOM_COLOR:  r_bot <= i_cfg_wdata;
                default:           ;
            endcase
        end
    end

    // ---- global advance: whole pipeline moves unless the output is held ----
    logic w_ce;
    logic r_ov;
    assign w_ce       = !r_ov || i_m_tready;
    assign o_s_tready = w_ce;

    // valid and sign travel together down one line
    logic r_vld [NLINE];
    logic r_neg [NLINE];
    logic w_neg_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NLINE; i++) r_vld[i] <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_ce) begin
            r_vld[0] <= i_s_tvalid;
            for (int i = 1; i < NLINE; i++) r_vld[i] <= r_vld[i-1];
            r_ov <= r_vld[NLINE-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_neg[0] <= w_neg_in;
            for (int i = 1; i < NLINE; i++) r_neg[i] <= r_neg[i-1];
        end
    end

    // ---- stage A: direction numerators ----
    logic [2:0]         w_face;
    logic [9:0]         w_row, w_col;
    logic signed [12:0] w_n, w_s, w_t, w_v;

    assign w_face = i_s_tdata[2:0];
    assign w_row  = i_s_tdata[12:3];
    assign w_col  = i_s_tdata[22:13];
    assign w_n    = signed'({2'b00, r_fsz});
    assign w_s    = signed'({2'b00, w_col, 1'b1}) - w_n;
    assign w_t    = w_n - signed'({2'b00, w_row, 1'b1});

    always_comb begin
        if (w_face == FACE_POS_Y)      w_v = w_n;
        else if (w_face == FACE_NEG_Y) w_v = -w_n;
        else                           w_v = w_t;
    end
    assign w_neg_in = w_v[12];

    logic signed [12:0] r_an, r_as, r_at, r_av;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_an <= w_n;
            r_as <= w_s;
            r_at <= w_t;
            r_av <= w_v;
        end
    end

    // ---- stage B: squares (each below 2^22) ----
    logic signed [25:0] w_nn, w_ss, w_tt, w_vv;
    assign w_nn = r_an * r_an;
    assign w_ss = r_as * r_as;
    assign w_tt = r_at * r_at;
    assign w_vv = r_av * r_av;

    logic [21:0] r_bnn, r_bss, r_btt, r_bvv;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_bnn <= w_nn[21:0];
            r_bss <= w_ss[21:0];
            r_btt <= w_tt[21:0];
            r_bvv <= w_vv[21:0];
        end
    end

    // ---- stage C: D = N^2 + S^2 + T^2 (fits 24 bits, V^2 <= D) ----
    logic [23:0] r_cd;
    logic [21:0] r_cvv;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_cd  <= 24'(r_bnn) + 24'(r_bss) + 24'(r_btt);
            r_cvv <= r_bvv;
        end
    end

    // ---- divider: q = floor(V^2 * 2^32 / D), one quotient bit per stage ----
    logic [32:0] r_dq [NDIV];
    logic [24:0] r_dr [NDIV];
    logic [23:0] r_dd [NDIV];

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [25:0] w_rx;
        logic [32:0] w_qin;
        logic [23:0] w_din;
        logic        w_ge;
        if (k == 0) begin : g_first
            assign w_rx  = 26'(r_cvv);
            assign w_qin = '0;
            assign w_din = r_cd;
        end else begin : g_next
            assign w_rx  = {r_dr[k-1], 1'b0};
            assign w_qin = r_dq[k-1];
            assign w_din = r_dd[k-1];
        end
        assign w_ge = (w_rx >= 26'(w_din));
        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_dq[k] <= {w_qin[31:0], w_ge};
                r_dr[k] <= w_ge ? 25'(w_rx - 26'(w_din)) : w_rx[24:0];
                r_dd[k] <= w_din;
            end
        end
    end

    // ---- square roots, one root bit per stage ----
    function automatic t_sq sq_step(t_sq a);
        t_sq         o;
        logic [19:0] rx, trial;
        rx    = {a.rem[17:0], a.rad[33:32]};
        trial = {1'b0, a.root, 2'b01};
        o.rad = {a.rad[31:0], 2'b00};
        if (rx >= trial) begin
            o.rem  = rx - trial;
            o.root = {a.root[15:0], 1'b1};
        end else begin
            o.rem  = rx;
            o.root = {a.root[15:0], 1'b0};
        end
        return o;
    endfunction

    t_sq r_sq1 [NSQ];
    t_sq r_sq2 [NSQ];
    t_sq w_sq1_in, w_sq2_in;

    assign w_sq1_in = '{rad: {1'b0, r_dq[NDIV-1]}, rem: '0, root: '0};
    assign w_sq2_in = '{rad: {1'b0, r_sq1[NSQ-1].root, 16'h0000}, rem: '0, root: '0};

    for (genvar j = 0; j < NSQ; j++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_sq1[j] <= sq_step((j == 0) ? w_sq1_in : r_sq1[(j == 0) ? 0 : j-1]);
                r_sq2[j] <= sq_step((j == 0) ? w_sq2_in : r_sq2[(j == 0) ? 0 : j-1]);
            end
        end
    end

    // ---- colour mix and output register ----
    logic [15:0]      w_b;
    logic [16:0]      w_nb;
    logic [COL_W-1:0] w_far;
    logic [23:0]      w_mix;

    assign w_b   = r_sq2[NSQ-1].root[16] ? 16'hFFFF : r_sq2[NSQ-1].root[15:0];
    assign w_nb  = 17'h10000 - 17'(w_b);
    assign w_far = r_neg[NLINE-1] ? r_bot : r_top;

    always_comb begin
        logic [25:0] acc;
        w_mix = '0;
        for (int c = 0; c < 3; c++) begin
            // channel c: red from the high byte of the colour
            acc = 26'(r_hor[23-8*c -: 8]) * 26'(w_nb)
                + 26'(w_far[23-8*c -: 8]) * 26'(w_b);
            w_mix[8*c +: 8] = acc[23:16];
        end
    end

    logic [23:0] r_out;
    always_ff @(posedge i_clk) begin
        if (w_ce) r_out <= w_mix;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out;

endmodule

// ----- tb/sv/sky_texel_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sky_texel_checker
// Watches both streams and the register port, works out each texel colour
// and compares it, in order, with what the unit returns.
// ---------------------------------------------------------------------------
module sky_texel_checker
    import cfsg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [COL_W-1:0] i_cfg_wdata,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [23:0]      i_s_tdata,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [23:0]      i_m_tdata,
    output int               o_errors,
    output int               o_pending,
    output int               o_colours_seen
);

    logic [FSZ_W-1:0] face_size_q;
    logic [23:0]      top_q, horizon_q, bottom_q;
    logic [23:0]      colour_q[$];

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [23:0] sky_colour(logic [23:0] beat);
        logic [2:0]  face;
        longint      row, col, n, s, t, v;
        logic [63:0] d, vv, ay, b, acc;
        logic [23:0] far, rgb;
        logic [7:0]  h, x;
        face = beat[2:0];
        row  = longint'(beat[12:3]);
        col  = longint'(beat[22:13]);
        n    = longint'(face_size_q);
        s    = 2 * col + 1 - n;
        t    = n - 2 * row - 1;
        if (face == FACE_POS_Y) v = n;
        else if (face == FACE_NEG_Y) v = -n;
        else v = t;
        d  = n * n + s * s + t * t;
        vv = v * v;
        ay = isqrt((vv << 32) / d);
        b  = isqrt(ay << 16);
        if (b > 65535) b = 64'd65535;
        far = (v >= 0) ? top_q : bottom_q;
        // channel order swaps on the stream: red lowest byte
        for (int k = 0; k < 3; k++) begin
            h   = horizon_q[16 - 8 * k +: 8];
            x   = far[16 - 8 * k +: 8];
            acc = h * (64'd65536 - b) + x * b;
            rgb[8 * k +: 8] = acc[23:16];
        end
        return rgb;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            face_size_q <= FSZ_RESET;
            top_q       <= '0;
            horizon_q   <= '0;
            bottom_q    <= '0;
            o_errors    <= 0;
            o_colours_seen <= 0;
            colour_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_FACE_SIZE: begin
                        face_size_q <= (i_cfg_wdata[FSZ_W-1:0] > FSZ_MAX) ? FSZ_MAX
                                                                         : i_cfg_wdata[FSZ_W-1:0];
                    end
                    REG_TOP_COLOR:     top_q     <= i_cfg_wdata;
                    REG_HORIZON_COLOR: horizon_q <= i_cfg_wdata;
                    REG_BOTTOM_COLOR:  bottom_q  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) colour_q.push_back(sky_colour(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                o_colours_seen <= o_colours_seen + 1;
                if (colour_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("[%0t] unexpected colour beat %h", $time, i_m_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    if (colour_q[0] !== i_m_tdata) begin
                        if (o_errors < 10)
                            $display("[%0t] colour mismatch exp r%h g%h b%h got r%h g%h b%h",
                                $time, colour_q[0][7:0], colour_q[0][15:8],
                                colour_q[0][23:16], i_m_tdata[7:0], i_m_tdata[15:8],
                                i_m_tdata[23:16]);
                        o_errors <= o_errors + 1;
                    end
                    void'(colour_q.pop_front());
                end
            end
        end
    end

    assign o_pending = colour_q.size();

endmodule

// ----- tb/sv/tb_cube_face_sky_gradient_texel_unit.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_cube_face_sky_gradient_texel_unit
// Drives texel beats and register writes into the sky gradient unit; the
// checker beside it predicts every colour and reports mismatches.
// ---------------------------------------------------------------------------
module tb_cube_face_sky_gradient_texel_unit;
    import cfsg_pkg::*;

    localparam int LATENCY    = 71;
    localparam int STALL_LIMIT = 20000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [COL_W-1:0] cfg_wdata;
    logic             s_tvalid, s_tready;
    logic [23:0]      s_tdata;     // face[2:0], texel_row[12:3], texel_col[22:13]
    logic             m_tvalid, m_tready;
    logic [23:0]      m_tdata;     // red[7:0], green[15:8], blue[23:16]
    int               errors, pending, colours_seen;
    int               idle_cycles;
    int               texels_sent;
    bit               calm;        // no idling on either side while set
    bit               timed_out;

    cube_face_sky_gradient_texel_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    sky_texel_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending), .o_colours_seen(colours_seen)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // sink side: random back-pressure, none during calm stretches
    always @(posedge clk) begin
        if (!rst_n) m_tready <= 1'b0;
        else        m_tready <= calm || ($urandom_range(99) >= 38);
    end

    // watchdog: cycles with no beat accepted on either stream
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // one write, then a pause with cfg_we low so back-to-back writes never clash
    task automatic write_reg(t_reg_idx idx, logic [COL_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every colour, then let the pipe drain before touching registers
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // one texel beat, with a random gap first unless calm
    task automatic send_texel(logic [2:0] face, logic [9:0] row, logic [9:0] col);
        while (!calm && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, col, row, face};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        texels_sent++;
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_colours(logic [23:0] top, logic [23:0] hor, logic [23:0] bot);
        write_reg(REG_TOP_COLOR, top);
        write_reg(REG_HORIZON_COLOR, hor);
        write_reg(REG_BOTTOM_COLOR, bot);
    endtask

    // random texels for the current setting; mostly within the face
    task automatic random_texels(int count, int fsz);
        logic [9:0] row, col;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) < 8 && fsz > 0) begin
                row = 10'($urandom_range(fsz - 1));
                col = 10'($urandom_range(fsz - 1));
            end else begin
                row = 10'($urandom);
                col = 10'($urandom);
            end
            send_texel(3'($urandom_range(7)), row, col);
        end
        end_burst();
    endtask

    initial begin
        int sizes[8];
        rst_n = 1'b0;  cfg_we = 1'b0;  cfg_idx = '0;  cfg_wdata = '0;
        s_tvalid = 1'b0;  s_tdata = '0;  calm = 1'b0;  timed_out = 1'b0;
        texels_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset colours are all black: a few beats at reset face size
        send_texel(3'd0, 10'd0, 10'd0);
        send_texel(3'd2, 10'd128, 10'd128);
        end_burst();
        drain();

        // directed: every face, corners, zenith/nadir, extrapolated coords
        set_colours(24'hFFFFFF, 24'h000000, 24'h80FF01);
        write_reg(REG_FACE_SIZE, 24'd1024);
        for (int f = 0; f < 8; f++) send_texel(f[2:0], 10'd0, 10'd0);
        send_texel(3'd4, 10'd1023, 10'd1023);
        send_texel(3'd0, 10'd511, 10'd512);
        send_texel(3'd5, 10'd512, 10'd511);
        send_texel(3'd2, 10'd511, 10'd511);
        send_texel(3'd3, 10'd512, 10'd512);
        end_burst();
        drain();
        write_reg(REG_FACE_SIZE, 24'd2047);     // saturates to the maximum
        send_texel(3'd1, 10'h2AA, 10'h155);
        end_burst();
        drain();
        write_reg(REG_FACE_SIZE, 24'd0);        // zero size still defined
        send_texel(3'd0, 10'd0, 10'd0);
        send_texel(3'd3, 10'd1023, 10'd0);
        send_texel(3'd2, 10'd0, 10'd1023);
        end_burst();
        drain();
        write_reg(REG_FACE_SIZE, 24'd1);
        set_colours(24'h000000, 24'hFFFFFF, 24'hFFFFFF);
        send_texel(3'd6, 10'd0, 10'd0);
        send_texel(3'd7, 10'd1023, 10'd1023);
        send_texel(3'd2, 10'd0, 10'd0);
        end_burst();
        drain();

        // random phases over several sizes and colour sets
        sizes = '{2, 4, 16, 64, 255, 512, 1024, 1};
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_FACE_SIZE, (p == 6) ? 24'd1500 : COL_W'(sizes[p]));
            if (p == 1) set_colours(24'hFFFFFF, 24'hFFFFFF, 24'h000000);
            else set_colours(24'($urandom), 24'($urandom), 24'($urandom));
            calm = (p == 3);
            random_texels(230, sizes[p]);
            calm = 1'b0;
            drain();
        end

        $display("covered %0d texel beats over 10 register settings, %0d colours checked",
                 texels_sent, colours_seen);
        $display("face sizes 0..1024 plus saturation, all faces incl. 6/7, out-of-face coords");
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
